// ===== src/tmmc_pkg.sv =====
// ---------------------------------------------------------------------------
// Two-button menu mode controller package
// Shared types, codes and register reset values for the menu controller.
// ---------------------------------------------------------------------------
package tmmc_pkg;

  // Field widths of the item channels.
  localparam int unsigned OP_W      = 2;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned FWD_W     = 2;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Register reset values.
  localparam logic [CNT_W-1:0] ENTRY_COUNT_RST    = 5'd1;
  localparam logic [MS_W-1:0]  HOLD_MS_RST        = 16'd1000;
  localparam logic [MS_W-1:0]  SELECT_WAIT_MS_RST = 16'd1000;
  localparam logic [MS_W-1:0]  TEXT_PERIOD_MS_RST = 16'd50;

  // Input item operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_BTN_ONE = 2'd0,
    OP_BTN_TWO = 2'd1,
    OP_TICK    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Menu modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_RUN    = 2'd0,
    MODE_CHORD  = 2'd1,
    MODE_SELECT = 2'd2,
    MODE_WAIT   = 2'd3
  } mode_e;

  // Selection step directions.
  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_BACK = 2'd1,
    STEP_FWD  = 2'd2
  } step_e;

  // Forwarded button codes.
  typedef enum logic [FWD_W-1:0] {
    FWD_NONE    = 2'd0,
    FWD_BTN_ONE = 2'd1,
    FWD_BTN_TWO = 2'd2
  } fwd_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRY_COUNT    = 2'd0,
    CFG_HOLD_MS        = 2'd1,
    CFG_SELECT_WAIT_MS = 2'd2,
    CFG_TEXT_PERIOD_MS = 2'd3
  } cfg_idx_e;

  // One result item.
  typedef struct packed {
    mode_e            mode;
    logic [IDX_W-1:0] entry_index;
    fwd_e             forward_button;
    logic             forward_level;
    logic             entry_exit;
    logic             entry_restart;
    logic             entry_run;
    logic             show_name;
    logic             text_refresh;
  } out_item_t;

endpackage

// ===== src/tmmc_if.sv =====
// ---------------------------------------------------------------------------
// Menu controller channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ---------------------------------------------------------------------------

// Input item channel.
interface tmmc_in_if import tmmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic              level;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, op, level, now_ms, input ready);
  modport sink (input valid, op, level, now_ms, output ready);
endinterface

// Result item channel.
interface tmmc_out_if import tmmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0]  entry_index;
  logic [FWD_W-1:0]  forward_button;
  logic              forward_level;
  logic              entry_exit;
  logic              entry_restart;
  logic              entry_run;
  logic              show_name;
  logic              text_refresh;

  modport source (
    output valid, mode, entry_index, forward_button, forward_level, entry_exit,
           entry_restart, entry_run, show_name, text_refresh,
    input  ready
  );
  modport sink (
    input  valid, mode, entry_index, forward_button, forward_level, entry_exit,
           entry_restart, entry_run, show_name, text_refresh,
    output ready
  );
endinterface

// Register write channel.
interface tmmc_cfg_if import tmmc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/tmmc_select.sv =====
// ---------------------------------------------------------------------------
// Menu entry selection step
// Clamps the entry count and moves the selection backward or forward with wrap.
// ---------------------------------------------------------------------------
module tmmc_select import tmmc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic [$clog2(MAX_ENTRIES)-1:0] sel_i,
  input  logic [CNT_W-1:0]               count_i,
  input  logic                           norm_i,
  input  step_e                          step_i,
  output logic [$clog2(MAX_ENTRIES)-1:0] sel_o
);

  localparam int unsigned SEL_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CMP_W = ((SEL_W > CNT_W) ? SEL_W : CNT_W) + 1;

  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] max_ext;
  logic [CMP_W-1:0] eff;
  logic [CMP_W-1:0] sel_ext;
  logic [CMP_W-1:0] sel_norm;
  logic [CMP_W-1:0] sel_inc;
  logic [CMP_W-1:0] sel_next;

  // An entry count of zero acts as one; above the maximum it saturates.
  always_comb begin
    cnt_ext = CMP_W'(count_i);
    max_ext = CMP_W'(MAX_ENTRIES);
    if (cnt_ext == '0) begin
      eff = CMP_W'(1);
    end else if (cnt_ext > max_ext) begin
      eff = max_ext;
    end else begin
      eff = cnt_ext;
    end
  end

  // Normalize a selection that lies beyond the count, then apply the step.
  always_comb begin
    sel_ext  = CMP_W'(sel_i);
    sel_norm = (norm_i && (sel_ext >= eff)) ? '0 : sel_ext;
    sel_inc  = sel_norm + CMP_W'(1);
    case (step_i)
      STEP_BACK: begin
        if ((sel_norm == '0) || (sel_norm >= eff)) begin
          sel_next = eff - CMP_W'(1);
        end else begin
          sel_next = sel_norm - CMP_W'(1);
        end
      end
      STEP_FWD: begin
        sel_next = (sel_inc >= eff) ? '0 : sel_inc;
      end
      default: begin
        sel_next = sel_norm;
      end
    endcase
  end

  assign sel_o = sel_next[SEL_W-1:0];

endmodule

// ===== src/two_button_menu_mode_controller.sv =====
// ---------------------------------------------------------------------------
// Two-button menu mode controller
// Tracks two buttons and a four-state menu mode, steps the selected entry and
// produces forwarded button events and entry control pulses for each item.
// ---------------------------------------------------------------------------
// A result item is registered and valid in the cycle after its input is accepted.
// Throughput: one item per cycle unless stalled; the update is one pass of logic
// from the accepted item and the state registers into the result register.
// The input is ready whenever the result register is empty or being drained.
// Asynchronous reset clears all state but the result data and loads the defaults.
module two_button_menu_mode_controller import tmmc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmmc_in_if.sink    in_i,
  tmmc_out_if.source out_o,
  tmmc_cfg_if.sink   cfg_i
);

  localparam int unsigned SEL_W  = $clog2(MAX_ENTRIES);
  localparam int unsigned IDXE_W = (SEL_W > IDX_W) ? SEL_W : IDX_W;

  // Configuration registers.
  logic [CNT_W-1:0] entry_count_q;
  logic [MS_W-1:0]  hold_ms_q;
  logic [MS_W-1:0]  select_wait_ms_q;
  logic [MS_W-1:0]  text_period_ms_q;

  // Controller state.
  logic              btn_one_q, btn_one_d;
  logic              btn_two_q, btn_two_d;
  logic [TIME_W-1:0] press_one_q, press_one_d;
  logic [TIME_W-1:0] press_two_q, press_two_d;
  mode_e             mode_q, mode_d;
  step_e             pending_q, pending_d;
  logic [SEL_W-1:0]  sel_q, sel_d;
  logic [TIME_W-1:0] switch_time_q, switch_time_d;
  logic [TIME_W-1:0] refresh_time_q, refresh_time_d;

  // Result register.
  logic      out_valid_q;
  out_item_t out_q, out_d;

  logic              in_fire;
  op_e               op;
  logic [TIME_W-1:0] now;
  logic              norm;
  step_e             step;
  logic [SEL_W-1:0]  sel_moved;
  logic [IDXE_W-1:0] sel_wide;
  logic [TIME_W-1:0] held_one;
  logic [TIME_W-1:0] held_two;
  logic [TIME_W-1:0] quiet;
  logic [TIME_W-1:0] since_refresh;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign op          = op_e'(in_i.op);
  assign now         = in_i.now_ms;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q    <= ENTRY_COUNT_RST;
      hold_ms_q        <= HOLD_MS_RST;
      select_wait_ms_q <= SELECT_WAIT_MS_RST;
      text_period_ms_q <= TEXT_PERIOD_MS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_ENTRY_COUNT:    entry_count_q    <= cfg_i.data[CNT_W-1:0];
        CFG_HOLD_MS:        hold_ms_q        <= cfg_i.data[MS_W-1:0];
        CFG_SELECT_WAIT_MS: select_wait_ms_q <= cfg_i.data[MS_W-1:0];
        CFG_TEXT_PERIOD_MS: text_period_ms_q <= cfg_i.data[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Elapsed times, all modulo the timestamp width.
  assign held_one      = now - press_one_q;
  assign held_two      = now - press_two_q;
  assign quiet         = now - switch_time_q;
  assign since_refresh = now - refresh_time_q;

  // Selection stepping and wrap.
  tmmc_select #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_select (
    .sel_i   (sel_q),
    .count_i (entry_count_q),
    .norm_i  (norm),
    .step_i  (step),
    .sel_o   (sel_moved)
  );

  // Next state and result for the item on the input.
  always_comb begin
    btn_one_d      = btn_one_q;
    btn_two_d      = btn_two_q;
    press_one_d    = press_one_q;
    press_two_d    = press_two_q;
    mode_d         = mode_q;
    pending_d      = pending_q;
    sel_d          = sel_q;
    switch_time_d  = switch_time_q;
    refresh_time_d = refresh_time_q;
    norm           = 1'b0;
    step           = STEP_NONE;
    out_d          = '0;

    case (op)
      OP_BTN_ONE, OP_BTN_TWO: begin
        if (op == OP_BTN_ONE) begin
          btn_one_d = in_i.level;
          if (in_i.level) begin
            press_one_d = now;
          end
        end else begin
          btn_two_d = in_i.level;
          if (in_i.level) begin
            press_two_d = now;
          end
        end
        if (mode_q == MODE_RUN) begin
          out_d.forward_button = (op == OP_BTN_ONE) ? FWD_BTN_ONE : FWD_BTN_TWO;
          out_d.forward_level  = in_i.level;
        end else if ((mode_q == MODE_SELECT) && !in_i.level) begin
          pending_d = (op == OP_BTN_ONE) ? STEP_BACK : STEP_FWD;
        end
      end
      OP_TICK: begin
        // Mode transitions.
        if (btn_one_q && btn_two_q) begin
          if (mode_q == MODE_RUN) begin
            if ((held_one > TIME_W'(hold_ms_q)) && (held_two > TIME_W'(hold_ms_q))) begin
              mode_d           = MODE_CHORD;
              norm             = 1'b1;
              out_d.show_name  = 1'b1;
              out_d.entry_exit = 1'b1;
            end
          end else if (mode_q == MODE_SELECT) begin
            mode_d              = MODE_WAIT;
            out_d.entry_restart = 1'b1;
          end
        end else if (!btn_one_q && !btn_two_q) begin
          if (mode_q == MODE_CHORD) begin
            mode_d = MODE_SELECT;
          end else if (mode_q == MODE_SELECT) begin
            if (quiet > TIME_W'(select_wait_ms_q)) begin
              mode_d              = MODE_RUN;
              out_d.entry_restart = 1'b1;
            end
          end else if (mode_q == MODE_WAIT) begin
            mode_d = MODE_RUN;
          end
        end
        // Text refresh pacing in the select modes.
        if ((mode_d == MODE_CHORD) || (mode_d == MODE_SELECT)) begin
          if (since_refresh > TIME_W'(text_period_ms_q)) begin
            refresh_time_d     = now;
            out_d.text_refresh = 1'b1;
          end
        end
        // Run the entry, or apply a pending step.
        if ((mode_d == MODE_RUN) || (mode_d == MODE_WAIT)) begin
          out_d.entry_run = 1'b1;
        end else if (pending_q != STEP_NONE) begin
          step            = pending_q;
          out_d.show_name = 1'b1;
          pending_d       = STEP_NONE;
        end
        if (norm || (step != STEP_NONE)) begin
          sel_d         = sel_moved;
          switch_time_d = now;
        end
      end
      default: begin
      end
    endcase

    sel_wide          = IDXE_W'(sel_d);
    out_d.mode        = mode_d;
    out_d.entry_index = sel_wide[IDX_W-1:0];
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_one_q      <= 1'b0;
      btn_two_q      <= 1'b0;
      press_one_q    <= '0;
      press_two_q    <= '0;
      mode_q         <= MODE_RUN;
      pending_q      <= STEP_NONE;
      sel_q          <= '0;
      switch_time_q  <= '0;
      refresh_time_q <= '0;
    end else if (in_fire) begin
      btn_one_q      <= btn_one_d;
      btn_two_q      <= btn_two_d;
      press_one_q    <= press_one_d;
      press_two_q    <= press_two_d;
      mode_q         <= mode_d;
      pending_q      <= pending_d;
      sel_q          <= sel_d;
      switch_time_q  <= switch_time_d;
      refresh_time_q <= refresh_time_d;
    end
  end

  // Result register: filled on accept, emptied when the sink takes the item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.mode           = out_q.mode;
  assign out_o.entry_index    = out_q.entry_index;
  assign out_o.forward_button = out_q.forward_button;
  assign out_o.forward_level  = out_q.forward_level;
  assign out_o.entry_exit     = out_q.entry_exit;
  assign out_o.entry_restart  = out_q.entry_restart;
  assign out_o.entry_run      = out_q.entry_run;
  assign out_o.show_name      = out_q.show_name;
  assign out_o.text_refresh   = out_q.text_refresh;

  // The entry only runs while the menu is out of the select modes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.entry_run) |-> (out_q.mode == MODE_RUN || out_q.mode == MODE_WAIT))
    else $error("entry run reported in a select mode");

  // Leaving the entry always enters the chord mode and shows the name.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.entry_exit) |-> (out_q.mode == MODE_CHORD && out_q.show_name))
    else $error("entry exit without chord mode and name display");

  // A forwarded button event only happens in run mode and carries no pulses.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.forward_button != FWD_NONE) |->
      (out_q.mode == MODE_RUN && !out_q.entry_run && !out_q.show_name &&
       !out_q.text_refresh && !out_q.entry_restart))
    else $error("forwarded button outside run mode or with pulses");

  // Text refresh pulses only occur in the select modes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.text_refresh) |-> (out_q.mode == MODE_CHORD || out_q.mode == MODE_SELECT))
    else $error("text refresh outside the select modes");

  // A button item never changes the mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op == OP_BTN_ONE || op == OP_BTN_TWO)) |=> $stable(mode_q))
    else $error("mode changed on a button item");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Two-button menu mode controller testbench
// Drives button-change and tick items and register writes through the
// valid/ready channels, predicts every result item with an independent model
// of the menu controller, and compares each result field by field.
// ---------------------------------------------------------------------------
module testbench;
  import tmmc_pkg::*;

  localparam int unsigned MAX_ENTRIES  = 16;
  localparam longint      RUN_LIMIT_NS = 64'd5_000_000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 75;

  // One row of the directed plan: either an item or a register write.
  typedef struct {
    logic       is_reg;
    op_e        op;
    logic       lvl;
    logic [31:0] stamp;
    cfg_idx_e   idx;
    logic [15:0] data;
    logic       typed;
    out_item_t  want;
  } plan_row_t;

  logic clk;
  logic rst_n;

  tmmc_in_if  in_if ();
  tmmc_out_if out_if ();
  tmmc_cfg_if cfg_if ();

  two_button_menu_mode_controller #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Predicted register contents.
  logic [4:0]  reg_entry_count;
  logic [15:0] reg_hold_ms;
  logic [15:0] reg_wait_ms;
  logic [15:0] reg_text_ms;

  // Predicted controller state.
  logic        btn_one_held;
  logic        btn_two_held;
  logic [31:0] btn_one_since;
  logic [31:0] btn_two_since;
  mode_e       cur_mode;
  step_e       step_pending;
  logic [3:0]  cur_entry;
  logic [31:0] last_switch_ms;
  logic [31:0] last_text_ms;

  // Results the controller still owes, oldest first.
  out_item_t   pending_menu_out[$];
  plan_row_t   directed_plan[$];

  logic [31:0] wall_ms;
  logic        src_quiet;
  logic        snk_quiet;
  int unsigned items_sent;
  int unsigned directed_items;
  int unsigned results_checked;
  int unsigned regs_written;
  int unsigned exits_seen;
  int unsigned restarts_seen;
  int unsigned names_seen;
  int unsigned mismatches;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit on the run length.
  initial begin
    #(RUN_LIMIT_NS);
    $display("[two_button_menu_mode_controller] ERROR");
    $finish;
  end

  // Number of entries the wrap logic works with.
  function automatic logic [4:0] live_count();
    logic [4:0] c;
    c = reg_entry_count;
    if (c == 5'd0) c = 5'd1;
    if (c > 5'(MAX_ENTRIES)) c = 5'(MAX_ENTRIES);
    return c;
  endfunction

  // Moves the selected entry one step, or only normalizes it, and stamps it.
  function automatic void move_entry(step_e dir, logic [31:0] stamp);
    logic [4:0] c;
    logic [4:0] n;
    c = live_count();
    n = {1'b0, cur_entry} + 5'd1;
    case (dir)
      STEP_BACK: begin
        if (cur_entry == 4'd0 || {1'b0, cur_entry} >= c) n = c - 5'd1;
        else n = {1'b0, cur_entry} - 5'd1;
        cur_entry = n[3:0];
      end
      STEP_FWD: begin
        cur_entry = (n >= c) ? 4'd0 : n[3:0];
      end
      default: begin
        if ({1'b0, cur_entry} >= c) cur_entry = 4'd0;
      end
    endcase
    last_switch_ms = stamp;
  endfunction

  // Computes the result of one item and advances the predicted state.
  function automatic out_item_t menu_step(op_e op, logic lvl, logic [31:0] stamp);
    out_item_t r;
    r = '0;
    case (op)
      OP_BTN_ONE, OP_BTN_TWO: begin
        if (op == OP_BTN_ONE) begin
          btn_one_held = lvl;
          if (lvl) btn_one_since = stamp;
        end else begin
          btn_two_held = lvl;
          if (lvl) btn_two_since = stamp;
        end
        if (cur_mode == MODE_RUN) begin
          r.forward_button = (op == OP_BTN_ONE) ? FWD_BTN_ONE : FWD_BTN_TWO;
          r.forward_level  = lvl;
        end else if (cur_mode == MODE_SELECT && !lvl) begin
          step_pending = (op == OP_BTN_ONE) ? STEP_BACK : STEP_FWD;
        end
      end
      OP_TICK: begin
        if (btn_one_held && btn_two_held) begin
          if (cur_mode == MODE_RUN) begin
            if ((stamp - btn_one_since) > {16'h0, reg_hold_ms} &&
                (stamp - btn_two_since) > {16'h0, reg_hold_ms}) begin
              cur_mode = MODE_CHORD;
              move_entry(STEP_NONE, stamp);
              r.show_name  = 1'b1;
              r.entry_exit = 1'b1;
            end
          end else if (cur_mode == MODE_SELECT) begin
            cur_mode = MODE_WAIT;
            r.entry_restart = 1'b1;
          end
        end else if (!btn_one_held && !btn_two_held) begin
          case (cur_mode)
            MODE_CHORD: cur_mode = MODE_SELECT;
            MODE_SELECT: begin
              if ((stamp - last_switch_ms) > {16'h0, reg_wait_ms}) begin
                cur_mode = MODE_RUN;
                r.entry_restart = 1'b1;
              end
            end
            MODE_WAIT: cur_mode = MODE_RUN;
            default: ;
          endcase
        end
        // Scrolling text only advances while the menu is shown.
        if (cur_mode == MODE_CHORD || cur_mode == MODE_SELECT) begin
          if ((stamp - last_text_ms) > {16'h0, reg_text_ms}) begin
            last_text_ms   = stamp;
            r.text_refresh = 1'b1;
          end
        end
        if (cur_mode == MODE_RUN || cur_mode == MODE_WAIT) begin
          r.entry_run = 1'b1;
        end else if (step_pending != STEP_NONE) begin
          move_entry(step_pending, stamp);
          r.show_name  = 1'b1;
          step_pending = STEP_NONE;
        end
      end
      default: ;
    endcase
    r.mode        = cur_mode;
    r.entry_index = cur_entry;
    return r;
  endfunction

  // A result in run mode at entry zero, as seen right after reset.
  function automatic out_item_t run_result(fwd_e fb, logic fl, logic run);
    out_item_t r;
    r = '0;
    r.mode           = MODE_RUN;
    r.forward_button = fb;
    r.forward_level  = fl;
    r.entry_run      = run;
    return r;
  endfunction

  function automatic void plan_item(op_e op, logic lvl, logic [31:0] stamp);
    plan_row_t r;
    r.is_reg = 1'b0;
    r.op     = op;
    r.lvl    = lvl;
    r.stamp  = stamp;
    r.idx    = CFG_ENTRY_COUNT;
    r.data   = 16'h0;
    r.typed  = 1'b0;
    r.want   = '0;
    directed_plan.push_back(r);
  endfunction

  function automatic void plan_known(op_e op, logic lvl, logic [31:0] stamp,
                                     out_item_t want);
    plan_item(op, lvl, stamp);
    directed_plan[directed_plan.size()-1].typed = 1'b1;
    directed_plan[directed_plan.size()-1].want  = want;
  endfunction

  function automatic void plan_reg(cfg_idx_e idx, logic [15:0] data);
    plan_item(OP_NONE, 1'b0, 32'h0);
    directed_plan[directed_plan.size()-1].is_reg = 1'b1;
    directed_plan[directed_plan.size()-1].idx    = idx;
    directed_plan[directed_plan.size()-1].data   = data;
  endfunction

  function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Time step between events: tiny, near a threshold, wide, or anywhere.
  function automatic logic [31:0] pick_delta_ms(logic [15:0] thr);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return 32'($urandom_range(0, 3));
    if (pick < 7) return {16'h0, thr} + 32'($urandom_range(0, 2)) - 32'd1;
    if (pick < 9) return 32'($urandom_range(0, {16'h0, thr} * 32'd2 + 32'd2));
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_ms();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2000));
  endfunction

  // Offers one item and waits for it to be taken; predicts its result.
  task automatic send_event(op_e op, logic lvl, logic [31:0] stamp);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.op     <= op;
    in_if.level  <= lvl;
    in_if.now_ms <= stamp;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_menu_out.push_back(menu_step(op, lvl, stamp));
    if (op != OP_NONE) items_sent++;
    if ($urandom_range(0, 19) == 0) src_quiet = !src_quiet;
  endtask

  // Holds the input back until every owed result has come out.
  task automatic wait_all_results();
    if (in_if.valid) in_if.valid <= 1'b0;
    while (pending_menu_out.size() != 0) @(posedge clk);
  endtask

  // Writes one register; valid stays high so writes can follow back to back.
  task automatic write_register(cfg_idx_e idx, logic [15:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_ENTRY_COUNT:    reg_entry_count = data[4:0];
      CFG_HOLD_MS:        reg_hold_ms     = data;
      CFG_SELECT_WAIT_MS: reg_wait_ms     = data;
      CFG_TEXT_PERIOD_MS: reg_text_ms     = data;
      default: ;
    endcase
    regs_written++;
  endtask

  task automatic tick_after(logic [31:0] delta);
    wall_ms = wall_ms + delta;
    send_event(OP_TICK, 1'b0, wall_ms);
  endtask

  task automatic button_after(op_e btn, logic lvl, logic [31:0] delta);
    wall_ms = wall_ms + delta;
    send_event(btn, lvl, wall_ms);
  endtask

  // A full menu visit: chord, release, a few switches, then leave.
  task automatic menu_session();
    op_e first;
    op_e second;
    op_e btn;
    int unsigned clicks;
    first  = ($urandom_range(0, 1) == 1) ? OP_BTN_TWO : OP_BTN_ONE;
    second = (first == OP_BTN_ONE) ? OP_BTN_TWO : OP_BTN_ONE;
    button_after(first, 1'b1, 32'($urandom_range(0, 40)));
    button_after(second, 1'b1, 32'($urandom_range(0, 40)));
    if ($urandom_range(0, 1) == 1) tick_after(32'($urandom_range(0, 20)));
    tick_after({16'h0, reg_hold_ms} + 32'($urandom_range(0, 2)));
    tick_after(32'($urandom_range(1, 2)));
    button_after(first, 1'b0, 32'($urandom_range(0, 40)));
    if ($urandom_range(0, 1) == 1) tick_after(32'($urandom_range(0, 20)));
    button_after(second, 1'b0, 32'($urandom_range(0, 40)));
    tick_after(32'($urandom_range(0, 20)));
    // Switch through the entries.
    clicks = $urandom_range(0, 5);
    repeat (clicks) begin
      btn = ($urandom_range(0, 1) == 1) ? OP_BTN_TWO : OP_BTN_ONE;
      button_after(btn, 1'b1, 32'($urandom_range(0, 30)));
      if ($urandom_range(0, 1) == 1) tick_after(32'($urandom_range(0, 20)));
      button_after(btn, 1'b0, 32'($urandom_range(0, 30)));
      tick_after(pick_delta_ms(reg_text_ms));
    end
    // Leave by a chord in select mode or by waiting out the select time.
    if ($urandom_range(0, 4) == 0) begin
      button_after(first, 1'b1, 32'($urandom_range(0, 30)));
      button_after(second, 1'b1, 32'($urandom_range(0, 30)));
      tick_after(32'($urandom_range(0, 20)));
      button_after(first, 1'b0, 32'($urandom_range(0, 30)));
      button_after(second, 1'b0, 32'($urandom_range(0, 30)));
      tick_after(32'($urandom_range(0, 20)));
    end else begin
      tick_after({16'h0, reg_wait_ms} + 32'($urandom_range(0, 1)));
      tick_after(32'($urandom_range(1, 2)));
    end
  endtask

  // A short burst of unrelated items, idle codes included.
  task automatic button_noise();
    int unsigned n;
    op_e op;
    logic lvl;
    n = $urandom_range(1, 6);
    repeat (n) begin
      op  = op_e'($urandom_range(0, 3));
      lvl = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) wall_ms = $urandom;
      else wall_ms = wall_ms + pick_delta_ms(reg_hold_ms);
      send_event(op, lvl, wall_ms);
    end
  endtask

  // Result side: random stalls, then compare against the oldest prediction.
  initial begin : result_sink
    int unsigned stall;
    out_item_t want;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = snk_quiet ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      if (pending_menu_out.size() == 0) begin
        $error("result item arrived with no input item outstanding");
        mismatches++;
      end else begin
        want = pending_menu_out.pop_front();
        check_field("mode", 4'(want.mode), 4'(out_if.mode));
        check_field("entry_index", want.entry_index, out_if.entry_index);
        check_field("forward_button", 4'(want.forward_button), 4'(out_if.forward_button));
        check_field("forward_level", 4'(want.forward_level), 4'(out_if.forward_level));
        check_field("entry_exit", 4'(want.entry_exit), 4'(out_if.entry_exit));
        check_field("entry_restart", 4'(want.entry_restart), 4'(out_if.entry_restart));
        check_field("entry_run", 4'(want.entry_run), 4'(out_if.entry_run));
        check_field("show_name", 4'(want.show_name), 4'(out_if.show_name));
        check_field("text_refresh", 4'(want.text_refresh), 4'(out_if.text_refresh));
        results_checked++;
        if (want.entry_exit) exits_seen++;
        if (want.entry_restart) restarts_seen++;
        if (want.show_name) names_seen++;
      end
      if ($urandom_range(0, 19) == 0) snk_quiet = !snk_quiet;
    end
  end

  // Main sequence: reset, directed plan, then randomized phases.
  initial begin : stimulus
    plan_row_t row;
    logic [4:0]  cnt;
    logic [15:0] hold_v;
    logic [15:0] wait_v;
    logic [15:0] text_v;
    int unsigned target;

    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.op     = OP_NONE;
    in_if.level  = 1'b0;
    in_if.now_ms = 32'h0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_ENTRY_COUNT;
    cfg_if.data  = 16'h0;
    src_quiet    = 1'b0;
    snk_quiet    = 1'b0;
    wall_ms      = 32'h0;
    items_sent      = 0;
    results_checked = 0;
    regs_written    = 0;
    exits_seen      = 0;
    restarts_seen   = 0;
    names_seen      = 0;
    mismatches      = 0;

    // Register defaults and cleared state after reset.
    reg_entry_count = ENTRY_COUNT_RST;
    reg_hold_ms     = HOLD_MS_RST;
    reg_wait_ms     = SELECT_WAIT_MS_RST;
    reg_text_ms     = TEXT_PERIOD_MS_RST;
    btn_one_held    = 1'b0;
    btn_two_held    = 1'b0;
    btn_one_since   = 32'h0;
    btn_two_since   = 32'h0;
    cur_mode        = MODE_RUN;
    step_pending    = STEP_NONE;
    cur_entry       = 4'd0;
    last_switch_ms  = 32'h0;
    last_text_ms    = 32'h0;

    // Idle code, ticks and presses with the reset defaults.
    plan_known(OP_NONE, 1'b1, 32'hFFFF_FFFF, run_result(FWD_NONE, 1'b0, 1'b0));
    plan_known(OP_TICK, 1'b0, 32'h0000_0000, run_result(FWD_NONE, 1'b0, 1'b1));
    plan_known(OP_BTN_ONE, 1'b1, 32'hFFFF_FF00, run_result(FWD_BTN_ONE, 1'b1, 1'b0));
    plan_known(OP_BTN_TWO, 1'b1, 32'hFFFF_FF00, run_result(FWD_BTN_TWO, 1'b1, 1'b0));
    // Held exactly the hold time across the time wrap: not yet a chord.
    plan_known(OP_TICK, 1'b0, 32'h0000_02E8, run_result(FWD_NONE, 1'b0, 1'b1));
    plan_item(OP_TICK, 1'b0, 32'h0000_02E9);
    plan_item(OP_BTN_ONE, 1'b0, 32'h0000_0300);
    plan_item(OP_BTN_TWO, 1'b0, 32'h0000_0300);
    plan_item(OP_TICK, 1'b0, 32'h0000_0310);
    // Oversized entry count saturates; backward step from entry zero wraps.
    plan_reg(CFG_ENTRY_COUNT, 16'd31);
    plan_item(OP_BTN_ONE, 1'b0, 32'h0000_0320);
    plan_item(OP_TICK, 1'b0, 32'h0000_0330);
    // Lowered count: backward step from beyond the count lands on the last.
    plan_reg(CFG_ENTRY_COUNT, 16'd4);
    plan_item(OP_BTN_ONE, 1'b0, 32'h0000_0340);
    plan_item(OP_TICK, 1'b0, 32'h0000_0350);
    // Chord while selecting restarts; the step stays pending.
    plan_item(OP_BTN_ONE, 1'b1, 32'h0000_0360);
    plan_item(OP_BTN_TWO, 1'b1, 32'h0000_0360);
    plan_item(OP_BTN_ONE, 1'b0, 32'h0000_0370);
    plan_item(OP_BTN_ONE, 1'b1, 32'h0000_0380);
    plan_item(OP_TICK, 1'b0, 32'h0000_0390);
    plan_item(OP_BTN_ONE, 1'b0, 32'h0000_03A0);
    plan_item(OP_BTN_TWO, 1'b0, 32'h0000_03A0);
    plan_item(OP_TICK, 1'b0, 32'h0000_03B0);
    // Chord entry with a leftover step: normalize, then step, one name pulse.
    plan_reg(CFG_ENTRY_COUNT, 16'd2);
    plan_reg(CFG_HOLD_MS, 16'd0);
    plan_item(OP_BTN_ONE, 1'b1, 32'h0000_03C0);
    plan_item(OP_BTN_TWO, 1'b1, 32'h0000_03C0);
    plan_item(OP_TICK, 1'b0, 32'h0000_03C1);
    // Zero select wait leaves select mode on the next quiet tick.
    plan_reg(CFG_SELECT_WAIT_MS, 16'd0);
    plan_reg(CFG_TEXT_PERIOD_MS, 16'hFFFF);
    plan_item(OP_BTN_ONE, 1'b0, 32'h0000_03C8);
    plan_item(OP_BTN_TWO, 1'b0, 32'h0000_03C8);
    plan_item(OP_TICK, 1'b0, 32'h0000_03D0);
    plan_item(OP_TICK, 1'b0, 32'h0000_03D2);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed plan.
    for (int i = 0; i < directed_plan.size(); i++) begin
      row = directed_plan[i];
      if (row.is_reg) begin
        wait_all_results();
        write_register(row.idx, row.data);
        if (i + 1 == directed_plan.size() || !directed_plan[i+1].is_reg) begin
          cfg_if.valid <= 1'b0;
        end
      end else begin
        send_event(row.op, row.lvl, row.stamp);
        if (row.typed) pending_menu_out[pending_menu_out.size()-1] = row.want;
      end
    end
    directed_items = items_sent;

    // Random phases, each with its own register setting.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        cnt    = 5'd0;
        hold_v = 16'h0;
        wait_v = 16'h0;
        text_v = 16'h0;
      end else if (ph == 1) begin
        cnt    = 5'd31;
        hold_v = 16'hFFFF;
        wait_v = 16'hFFFF;
        text_v = 16'hFFFF;
      end else begin
        if ($urandom_range(0, 3) == 0) cnt = 5'($urandom_range(0, 31));
        else cnt = 5'($urandom_range(1, 16));
        hold_v = pick_ms();
        wait_v = pick_ms();
        text_v = pick_ms();
      end
      wait_all_results();
      write_register(CFG_ENTRY_COUNT, {11'h0, cnt});
      write_register(CFG_HOLD_MS, hold_v);
      write_register(CFG_SELECT_WAIT_MS, wait_v);
      write_register(CFG_TEXT_PERIOD_MS, text_v);
      cfg_if.valid <= 1'b0;
      // Odd phases start just below the time wrap.
      if (ph[0]) wall_ms = 32'hFFFF_0000 + 32'($urandom_range(0, 65535));
      else wall_ms = $urandom;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 6) menu_session();
        else button_noise();
        if ($urandom_range(0, 29) == 0) wait_all_results();
      end
    end

    // Let the last results drain and leave the block idle before the report.
    wait_all_results();
    repeat (4) @(posedge clk);

    $display("Sent %0d items (%0d directed) with %0d register writes.",
             items_sent, directed_items, regs_written);
    $display("Checked %0d results: %0d exits, %0d restarts, %0d name displays.",
             results_checked, exits_seen, restarts_seen, names_seen);
    if (mismatches == 0) begin
      $display("[two_button_menu_mode_controller] OK");
    end else begin
      $display("[two_button_menu_mode_controller] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tmmc_pkg.sv
src/tmmc_if.sv
src/tmmc_select.sv
src/two_button_menu_mode_controller.sv
tb/sv/testbench.sv
